@@ sv/tvn_pkg.sv @@
// ----------------------------------------------------------------------------
// Tileable value noise package
// Shared constants and hash helper functions for the fractal value noise unit.
// ----------------------------------------------------------------------------
package tvn_pkg;

  localparam int COORD_BITS = 16;
  localparam int QW         = 17;

  localparam logic [31:0] MIX_K1  = 32'h7feb352d;
  localparam logic [31:0] MIX_K2  = 32'h846ca68b;
  localparam logic [31:0] HASH_KX = 32'h9E3779B9;
  localparam logic [31:0] HASH_KS = 32'h85EBCA6B;

  localparam logic [19:0] FADE_C15 = 20'd983040;
  localparam logic [19:0] FADE_C10 = 20'd655360;
  localparam logic [16:0] ONE16    = 17'd65536;

  typedef enum logic [1:0] {
    REG_PERIOD_X     = 2'd0,
    REG_PERIOD_Y     = 2'd1,
    REG_NOISE_SEED   = 2'd2,
    REG_OCTAVE_COUNT = 2'd3
  } reg_index_t;

  function automatic logic [31:0] mix_a(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 16);
    return y * MIX_K1;
  endfunction

  function automatic logic [31:0] mix_b(input logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 15);
    return y * MIX_K2;
  endfunction

  function automatic logic [31:0] mix_c(input logic [31:0] x);
    return x ^ (x >> 16);
  endfunction

endpackage

@@ sv/tileable_value_noise_fbm_unit.sv @@
// ----------------------------------------------------------------------------
// Tileable fractal value noise unit
// A texel coordinate goes in, a normalised periodic fbm value comes out.
// ----------------------------------------------------------------------------
// The unit takes one coordinate word per cycle unless the output stalls, and
// gives one noise word for each word taken, through the chain of octave cells
// (nine stages each, one cell per octave) and the seventeen divider steps that
// normalise the weighted sum. A stall on the output holds the whole pipeline.
// Configuration must be written only while idle; the unit does not enforce it.
// ----------------------------------------------------------------------------
module tileable_value_noise_fbm_unit import tvn_pkg::*; #(
  parameter int PERIOD_MAX  = 1024,
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        coord_valid,
  output logic        coord_stall,
  input  logic [15:0] coord_u,
  input  logic [15:0] coord_v,
  output logic        noise_valid,
  input  logic        noise_stall,
  output logic [15:0] noise_value
);

  localparam int PW = $clog2(PERIOD_MAX+1);
  localparam int NW = $clog2(MAX_OCTAVES+1);
  localparam int SW = 16 + MAX_OCTAVES;

  logic [10:0]   period_x, period_y;
  logic [31:0]   noise_seed;
  logic [3:0]    octave_count;

  logic [PW-1:0] px, py;
  logic [NW-1:0] n;
  logic [MAX_OCTAVES:0] dfull;
  logic [MAX_OCTAVES-1:0] dv;
  logic          adv;

  logic          cv [MAX_OCTAVES+1];
  logic [15:0]   cu [MAX_OCTAVES+1];
  logic [15:0]   cvv [MAX_OCTAVES+1];
  logic [SW-1:0] cs [MAX_OCTAVES+1];

  logic          qv [QW+1];
  logic [SW-1:0] qr [QW+1];
  logic [QW-1:0] qq [QW+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      period_x     <= 11'd4;
      period_y     <= 11'd4;
      noise_seed   <= 32'd0;
      octave_count <= 4'd3;
    end else if (cfg_write) begin
      case (reg_index_t'(cfg_index))
        REG_PERIOD_X:     period_x     <= cfg_data[10:0];
        REG_PERIOD_Y:     period_y     <= cfg_data[10:0];
        REG_NOISE_SEED:   noise_seed   <= cfg_data;
        REG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (period_x == '0) begin
      px = PW'(1);
    end else if (32'(period_x) > PERIOD_MAX) begin
      px = PW'(PERIOD_MAX);
    end else begin
      px = PW'(period_x);
    end
    if (period_y == '0) begin
      py = PW'(1);
    end else if (32'(period_y) > PERIOD_MAX) begin
      py = PW'(PERIOD_MAX);
    end else begin
      py = PW'(period_y);
    end
    if (32'(octave_count) > MAX_OCTAVES) begin
      n = NW'(MAX_OCTAVES);
    end else begin
      n = NW'(octave_count);
    end
    dfull = ((MAX_OCTAVES+1)'(1) << n) - (MAX_OCTAVES+1)'(1);
    dv    = dfull[MAX_OCTAVES-1:0];
  end

  assign adv         = !(noise_valid && noise_stall);
  assign coord_stall = !adv;

  assign cv[0]  = coord_valid;
  assign cu[0]  = coord_u;
  assign cvv[0] = coord_v;
  assign cs[0]  = '0;

  for (genvar o = 0; o < MAX_OCTAVES; o++) begin : g_cell
    tvn_cell #(
      .OCT(o), .PERIOD_MAX(PERIOD_MAX), .MAX_OCTAVES(MAX_OCTAVES)
    ) u_cell (
      .clk(clk), .rst(rst), .adv(adv),
      .px(px), .py(py), .seed(noise_seed), .n(n),
      .in_valid(cv[o]), .in_u(cu[o]), .in_v(cvv[o]), .in_sum(cs[o]),
      .out_valid(cv[o+1]), .out_u(cu[o+1]), .out_v(cvv[o+1]), .out_sum(cs[o+1])
    );
  end

  assign qv[0] = cv[MAX_OCTAVES];
  assign qr[0] = cs[MAX_OCTAVES];
  assign qq[0] = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    tvn_div_step #(
      .SW(SW), .DW(MAX_OCTAVES), .BIT(QW-1-k)
    ) u_step (
      .clk(clk), .rst(rst), .adv(adv), .d(dv),
      .in_valid(qv[k]), .in_rem(qr[k]), .in_q(qq[k]),
      .out_valid(qv[k+1]), .out_rem(qr[k+1]), .out_q(qq[k+1])
    );
  end

  assign noise_valid = qv[QW];

  always_comb begin
    if (n == '0) begin
      noise_value = '0;
    end else if (qq[QW][QW-1]) begin
      noise_value = 16'hFFFF;
    end else begin
      noise_value = qq[QW][15:0];
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    (noise_valid && (n != '0)) |-> !qq[QW][QW-1])
    else $error("normalised sum exceeds full scale");

endmodule

@@ sv/tvn_cell.sv @@
// ----------------------------------------------------------------------------
// Octave cell
// Computes one octave of value noise over nine stages and, if the octave is
// enabled by n, adds it, weighted, to the running sum from the previous cell.
// ----------------------------------------------------------------------------
module tvn_cell import tvn_pkg::*; #(
  parameter int OCT         = 0,
  parameter int PERIOD_MAX  = 1024,
  parameter int MAX_OCTAVES = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic [$clog2(PERIOD_MAX+1)-1:0]     px,
  input  logic [$clog2(PERIOD_MAX+1)-1:0]     py,
  input  logic [31:0]                         seed,
  input  logic [$clog2(MAX_OCTAVES+1)-1:0]    n,
  input  logic                                in_valid,
  input  logic [15:0]                         in_u,
  input  logic [15:0]                         in_v,
  input  logic [16+MAX_OCTAVES-1:0]           in_sum,
  output logic                                out_valid,
  output logic [15:0]                         out_u,
  output logic [15:0]                         out_v,
  output logic [16+MAX_OCTAVES-1:0]           out_sum
);

  localparam int PW  = $clog2(PERIOD_MAX+1);
  localparam int OPW = PW + OCT;
  localparam int NW  = $clog2(MAX_OCTAVES+1);
  localparam int SW  = 16 + MAX_OCTAVES;
  localparam int STG = 9;
  localparam int PRW = COORD_BITS + OPW;
  localparam logic [NW-1:0] OCT1 = NW'(OCT + 1);

  logic [STG-1:0] vld;
  logic [15:0]    pu [STG];
  logic [15:0]    pv [STG];
  logic [SW-1:0]  ps [STG-1];

  logic [OPW-1:0] pxo, pyo;
  logic [PRW-1:0] prx, pry;
  logic [31:0]    sk;

  logic [OPW-1:0] x0, y0, x1, y1;
  logic [OPW:0]   x1n, y1n;
  logic [15:0]    tx2, ty2;
  logic [31:0]    xk0, xk1, ym0, ym1;

  logic [15:0]    tx3, ty3, t2x, t2y;
  logic [19:0]    mx, my;
  logic [31:0]    xk0b, xk1b, ym0b, ym1b;
  logic [19:0]    mqx, mqy;
  logic [35:0]    mpx, mpy;
  logic [31:0]    t2px, t2py;

  logic [15:0]    t3x, t3y;
  logic [19:0]    dfx, dfy;
  logic [31:0]    d00, d01, d10, d11;
  logic [31:0]    t3px, t3py;
  logic [31:0]    in0, in1;

  logic [16:0]    fx5, fy5;
  logic [31:0]    e00, e01, e10, e11;
  logic [35:0]    fpx, fpy;

  logic [16:0]    fx6, fy6;
  logic [15:0]    c00, c01, c10, c11;

  logic [16:0]    fy7;
  logic [15:0]    la, lb;
  logic [31:0]    lap, lbp;

  logic [15:0]    val;
  logic [31:0]    vp;
  logic [NW-1:0]  shamt;
  logic [SW-1:0]  sum9;

  assign pxo = OPW'(px) << OCT;
  assign pyo = OPW'(py) << OCT;

  always_comb begin
    x0   = prx[COORD_BITS +: OPW];
    y0   = pry[COORD_BITS +: OPW];
    x1n  = {1'b0, x0} + (OPW+1)'(1);
    y1n  = {1'b0, y0} + (OPW+1)'(1);
    x1   = (x1n >= {1'b0, pxo}) ? '0 : x1n[OPW-1:0];
    y1   = (y1n >= {1'b0, pyo}) ? '0 : y1n[OPW-1:0];
    mqx  = FADE_C15 - (20'(tx2) * 20'd6);
    mqy  = FADE_C15 - (20'(ty2) * 20'd6);
    mpx  = 36'(tx2) * 36'(mqx);
    mpy  = 36'(ty2) * 36'(mqy);
    t2px = 32'(tx2) * 32'(tx2);
    t2py = 32'(ty2) * 32'(ty2);
    t3px = 32'(t2x) * 32'(tx3);
    t3py = 32'(t2y) * 32'(ty3);
    in0  = mix_c(ym0b);
    in1  = mix_c(ym1b);
    fpx  = 36'(t3x) * 36'(dfx);
    fpy  = 36'(t3y) * 36'(dfy);
    lap  = 32'(c00) * 32'(ONE16 - fx6) + 32'(c10) * 32'(fx6);
    lbp  = 32'(c01) * 32'(ONE16 - fx6) + 32'(c11) * 32'(fx6);
    vp   = 32'(la) * 32'(ONE16 - fy7) + 32'(lb) * 32'(fy7);
    shamt = n - OCT1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[STG-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pu[0] <= in_u;
      pv[0] <= in_v;
      ps[0] <= in_sum;
      for (int k = 1; k < STG; k++) begin
        pu[k] <= pu[k-1];
        pv[k] <= pv[k-1];
      end
      for (int k = 1; k < STG-1; k++) begin
        ps[k] <= ps[k-1];
      end
      prx <= PRW'(in_u) * PRW'(pxo);
      pry <= PRW'(in_v) * PRW'(pyo);
      sk  <= (seed + 32'(OCT)) * HASH_KS;
      tx2 <= prx[COORD_BITS-1:0];
      ty2 <= pry[COORD_BITS-1:0];
      xk0 <= 32'(x0) * HASH_KX;
      xk1 <= 32'(x1) * HASH_KX;
      ym0 <= mix_a(32'(y0) ^ sk);
      ym1 <= mix_a(32'(y1) ^ sk);
      tx3  <= tx2;
      ty3  <= ty2;
      t2x  <= t2px[31:16];
      t2y  <= t2py[31:16];
      mx   <= mpx[35:16];
      my   <= mpy[35:16];
      xk0b <= xk0;
      xk1b <= xk1;
      ym0b <= mix_b(ym0);
      ym1b <= mix_b(ym1);
      t3x <= t3px[31:16];
      t3y <= t3py[31:16];
      dfx <= FADE_C10 - mx;
      dfy <= FADE_C10 - my;
      d00 <= mix_a(xk0b ^ in0);
      d10 <= mix_a(xk1b ^ in0);
      d01 <= mix_a(xk0b ^ in1);
      d11 <= mix_a(xk1b ^ in1);
      fx5 <= (fpx[35:16] > 20'(ONE16)) ? ONE16 : fpx[32:16];
      fy5 <= (fpy[35:16] > 20'(ONE16)) ? ONE16 : fpy[32:16];
      e00 <= mix_b(d00);
      e01 <= mix_b(d01);
      e10 <= mix_b(d10);
      e11 <= mix_b(d11);
      fx6 <= fx5;
      fy6 <= fy5;
      c00 <= 16'(mix_c(e00) >> 16);
      c01 <= 16'(mix_c(e01) >> 16);
      c10 <= 16'(mix_c(e10) >> 16);
      c11 <= 16'(mix_c(e11) >> 16);
      fy7 <= fy6;
      la  <= lap[31:16];
      lb  <= lbp[31:16];
      val <= vp[31:16];
      if (32'(n) > OCT) begin
        sum9 <= ps[STG-2] + (SW'(val) << shamt);
      end else begin
        sum9 <= ps[STG-2];
      end
    end
  end

  assign out_valid = vld[STG-1];
  assign out_u     = pu[STG-1];
  assign out_v     = pv[STG-1];
  assign out_sum   = sum9;

  a_fade_range: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> (fx5 <= ONE16) && (fy5 <= ONE16))
    else $error("fade weight exceeds one");

  a_cell_wrap: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (x1 < pxo) && (y1 < pyo) && (x0 < pxo) && (y0 < pyo))
    else $error("lattice corner outside octave period");

endmodule

@@ sv/tvn_div_step.sv @@
// ----------------------------------------------------------------------------
// Divider step
// One restoring step of the normalising division: settles one quotient bit.
// ----------------------------------------------------------------------------
module tvn_div_step import tvn_pkg::*; #(
  parameter int SW  = 24,
  parameter int DW  = 8,
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic [DW-1:0] d,
  input  logic          in_valid,
  input  logic [SW-1:0] in_rem,
  input  logic [QW-1:0] in_q,
  output logic          out_valid,
  output logic [SW-1:0] out_rem,
  output logic [QW-1:0] out_q
);

  logic [SW+QW-1:0] dsh;
  logic             take;

  assign dsh  = (SW+QW)'(d) << BIT;
  assign take = (SW+QW)'(in_rem) >= dsh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rem <= take ? SW'((SW+QW)'(in_rem) - dsh) : in_rem;
      out_q   <= take ? (in_q | (QW'(1) << BIT)) : in_q;
    end
  end

  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (d != '0)) |-> ((SW+QW)'(out_rem) < dsh))
    else $error("division remainder out of bound");

endmodule

@@ verif/tileable_value_noise_fbm_unit_test.sv @@
// ----------------------------------------------------------------------------
// Tileable fractal value noise unit test
// Drives coordinate words through the unit under random idling on both sides
// and compares each noise word with a behavioural prediction, over several
// register settings including the extremes.
// ----------------------------------------------------------------------------
module tileable_value_noise_fbm_unit_test;
  import tvn_pkg::*;

  localparam int LIMIT_MAX_OCTAVES = 8;
  localparam int LIMIT_PERIOD_MAX  = 1024;
  localparam int DRAIN_CYCLES      = 120;
  localparam int WATCHDOG_LIMIT    = 4000;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        coord_valid;
  logic        coord_stall;
  logic [15:0] coord_u;
  logic [15:0] coord_v;
  logic        noise_valid;
  logic        noise_stall;
  logic [15:0] noise_value;

  logic [10:0] period_x_reg;
  logic [10:0] period_y_reg;
  logic [31:0] seed_reg;
  logic [3:0]  octaves_reg;

  logic [15:0] expected_noise[$];
  int          mismatches;
  int          idle_cycles;
  int          stall_left;
  bit          idling_on;
  bit          noise_fire;

  tileable_value_noise_fbm_unit DUT (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .coord_valid (coord_valid),
    .coord_stall (coord_stall),
    .coord_u     (coord_u),
    .coord_v     (coord_v),
    .noise_valid (noise_valid),
    .noise_stall (noise_stall),
    .noise_value (noise_value)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bit [31:0] scramble(bit [31:0] x);
    x = x ^ (x >> 16);
    x = x * 32'h7feb352d;
    x = x ^ (x >> 15);
    x = x * 32'h846ca68b;
    x = x ^ (x >> 16);
    return x;
  endfunction

  function automatic bit [63:0] lattice_value(bit [31:0] cx, bit [31:0] cy, bit [31:0] seed);
    bit [31:0] h;
    h = scramble((cx * 32'h9E3779B9) ^ scramble(cy ^ (seed * 32'h85EBCA6B)));
    return 64'(h >> 16);
  endfunction

  function automatic bit [63:0] quintic(bit [63:0] t);
    bit [63:0] t2, t3, m, f;
    t2 = (t * t) >> 16;
    t3 = (t2 * t) >> 16;
    m  = (t * (64'd983040 - 64'd6 * t)) >> 16;
    f  = (t3 * (64'd655360 - m)) >> 16;
    return (f > 64'd65536) ? 64'd65536 : f;
  endfunction

  function automatic bit [63:0] blend(bit [63:0] a, bit [63:0] b, bit [63:0] f);
    return (a * (64'd65536 - f) + b * f) >> 16;
  endfunction

  function automatic bit [63:0] octave_noise(bit [63:0] u, bit [63:0] v, bit [63:0] px,
                                             bit [63:0] py, bit [31:0] seed);
    bit [63:0] pu, pv, x0, x1, y0, y1, fx, fy, a, b;
    pu = u * px;
    pv = v * py;
    x0 = pu >> 16;
    y0 = pv >> 16;
    x1 = (x0 + 1 >= px) ? 64'd0 : x0 + 1;
    y1 = (y0 + 1 >= py) ? 64'd0 : y0 + 1;
    fx = quintic(pu & 64'hFFFF);
    fy = quintic(pv & 64'hFFFF);
    a = blend(lattice_value(x0, y0, seed), lattice_value(x1, y0, seed), fx);
    b = blend(lattice_value(x0, y1, seed), lattice_value(x1, y1, seed), fx);
    return blend(a, b, fy);
  endfunction

  function automatic bit [63:0] usable_period(logic [10:0] p);
    if (p == 0) return 64'd1;
    return (p > LIMIT_PERIOD_MAX) ? 64'(LIMIT_PERIOD_MAX) : 64'(p);
  endfunction

  function automatic logic [15:0] predict_noise(logic [15:0] u, logic [15:0] v);
    int        n;
    bit [63:0] px, py, total, quotient;
    n = (octaves_reg > LIMIT_MAX_OCTAVES) ? LIMIT_MAX_OCTAVES : int'(octaves_reg);
    px = usable_period(period_x_reg);
    py = usable_period(period_y_reg);
    total = 0;
    if (n == 0) return 16'd0;
    for (int o = 0; o < n; o++) begin
      total += octave_noise(u, v, px << o, py << o, seed_reg + o) << (n - 1 - o);
    end
    quotient = total / ((64'd1 << n) - 1);
    return (quotient > 64'd65535) ? 16'hFFFF : quotient[15:0];
  endfunction

  function automatic int pick_wait();
    return idling_on ? $urandom_range(0, 9) : 0;
  endfunction

  task automatic write_reg(reg_index_t idx, logic [31:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_PERIOD_X:     period_x_reg = data[10:0];
      REG_PERIOD_Y:     period_y_reg = data[10:0];
      REG_NOISE_SEED:   seed_reg     = data;
      REG_OCTAVE_COUNT: octaves_reg  = data[3:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(logic [31:0] px, logic [31:0] py, logic [31:0] seed, logic [31:0] n);
    write_reg(REG_PERIOD_X, px);
    write_reg(REG_PERIOD_Y, py);
    write_reg(REG_NOISE_SEED, seed);
    write_reg(REG_OCTAVE_COUNT, n);
  endtask

  task automatic send_coord(logic [15:0] u, logic [15:0] v);
    int gap;
    bit taken;
    gap = pick_wait();
    if (gap > 0) begin
      coord_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coord_valid <= 1'b1;
    coord_u     <= u;
    coord_v     <= v;
    do begin
      @(negedge clk);
      taken = !coord_stall;
      @(posedge clk);
    end while (!taken);
    expected_noise.push_back(predict_noise(u, v));
  endtask

  task automatic drain();
    coord_valid <= 1'b0;
    while (expected_noise.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_reset_values();
    idling_on = 1'b0;
    send_coord(16'h0000, 16'h0000);
    send_coord(16'h1234, 16'hC0DE);
    send_coord(16'h4000, 16'h4000);
    drain();
  endtask

  task automatic test_coordinate_extremes();
    idling_on = 1'b1;
    configure(3, 5, 32'hFFFFFFFF, 8);
    send_coord(16'hFFFF, 16'hFFFF);
    send_coord(16'hFFFF, 16'h0000);
    send_coord(16'h0000, 16'hFFFF);
    send_coord(16'h8000, 16'h7FFF);
    send_coord(16'hAAAA, 16'h5555);
    send_coord(16'h5555, 16'hAAAA);
    drain();
  endtask

  task automatic test_register_extremes();
    idling_on = 1'b1;
    configure(0, 0, 0, 0);
    send_coord(16'h9999, 16'h3333);
    send_coord(16'hFFFF, 16'hFFFF);
    drain();
    configure(1, 1, 1, 1);
    send_coord(16'h7FFF, 16'h8001);
    send_coord(16'hFFFF, 16'h0001);
    drain();
    configure(1024, 1024, 32'h80000000, 8);
    send_coord(16'hFFFF, 16'hFFFF);
    send_coord(16'h0001, 16'hFFFE);
    drain();
    configure(2047, 1500, 32'hFFFFFFFF, 15);
    send_coord(16'hFFFF, 16'h8000);
    send_coord(16'h1357, 16'hFFFF);
    drain();
    configure(32'hFFFFFFFF, 32'hFFFFF801, 32'h12345678, 32'hFFFFFFF9);
    send_coord(16'hFEDC, 16'h0123);
    drain();
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 16; phase++) begin
      idling_on = ($urandom_range(0, 3) != 0);
      configure($urandom_range(0, 2047), $urandom_range(0, 2047), $urandom(),
                $urandom_range(0, 15));
      repeat (58) send_coord($urandom(), $urandom());
      drain();
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_write   <= 1'b0;
    cfg_index   <= REG_PERIOD_X;
    cfg_data    <= '0;
    coord_valid <= 1'b0;
    coord_u     <= '0;
    coord_v     <= '0;
    period_x_reg = 11'd4;
    period_y_reg = 11'd4;
    seed_reg     = 32'd0;
    octaves_reg  = 4'd3;
    mismatches   = 0;
    idling_on    = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_values();
    test_coordinate_extremes();
    test_register_extremes();
    test_random_settings();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // The output handshake is sampled mid-cycle, where every signal is settled.
  always @(negedge clk) begin
    if (rst) begin
      noise_fire  <= 1'b0;
      idle_cycles = 0;
    end else begin
      if ((coord_valid && !coord_stall) || (noise_valid && !noise_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else if (noise_valid && !noise_stall) begin
        noise_fire <= 1'b1;
        if (expected_noise.size() == 0) begin
          $error("noise_value: no word expected, actual %0h", noise_value);
          mismatches++;
        end else begin
          logic [15:0] want;
          want = expected_noise.pop_front();
          if (noise_value !== want) begin
            $error("noise_value: expected %0h, actual %0h", want, noise_value);
            mismatches++;
          end
        end
      end else begin
        noise_fire <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      noise_stall <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      noise_stall <= 1'b1;
      stall_left  <= stall_left - 1;
    end else begin
      noise_stall <= 1'b0;
      if (noise_fire) stall_left <= pick_wait();
    end
  end

endmodule
